// File: design/asn1tp_pkg.sv
// Shared types and constants for the ASN.1 time string parser.
package asn1tp_pkg;

  localparam int unsigned AccW  = 14;
  localparam int unsigned FldW  = 7;
  localparam int unsigned CntW  = 3;

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChZulu  = 8'h5A;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChDot   = 8'h2E;

  localparam logic [AccW-1:0] CenturyPivot = AccW'(50);
  localparam logic [AccW-1:0] Base2000     = AccW'(2000);
  localparam logic [AccW-1:0] Base1900     = AccW'(1900);

  // Position within the time string grammar
  typedef enum logic [3:0] {
    PH_YEAR,
    PH_MONTH,
    PH_DAY,
    PH_HOUR,
    PH_AFTER_HOUR,
    PH_MINUTE,
    PH_AFTER_MIN,
    PH_SECOND,
    PH_AFTER_SEC,
    PH_FRAC,
    PH_AFTER_FRAC,
    PH_OFFSET
  } phase_t;

  // Where a completed digit goes
  typedef enum logic [2:0] {
    DST_NONE,
    DST_YEAR,
    DST_MONTH,
    DST_DAY,
    DST_HOUR,
    DST_MINUTE,
    DST_SECOND
  } dst_t;

  typedef struct packed {
    phase_t            phase;
    logic [AccW-1:0]   acc;
    logic [CntW-1:0]   cnt;
    logic [AccW-1:0]   year;
    logic [FldW-1:0]   month;
    logic [FldW-1:0]   day;
    logic [FldW-1:0]   hour;
    logic [FldW-1:0]   minute;
    logic [FldW-1:0]   second;
    logic              failed;
    logic              finished;
  } parse_state_t;

  typedef struct packed {
    logic              ok;
    logic [AccW-1:0]   year;
    logic [FldW-1:0]   month;
    logic [FldW-1:0]   day;
    logic [FldW-1:0]   hour;
    logic [FldW-1:0]   minute;
    logic [FldW-1:0]   second;
  } parse_result_t;

  localparam parse_state_t StateReset = '{
    phase:    PH_YEAR,
    acc:      '0,
    cnt:      '0,
    year:     '0,
    month:    '0,
    day:      '0,
    hour:     '0,
    minute:   '0,
    second:   '0,
    failed:   1'b0,
    finished: 1'b0
  };

endpackage

// File: design/asn1tp_step.sv
// Per-character parse step: next parser state and the result for a final character.
module asn1tp_step import asn1tp_pkg::*; (
  input  parse_state_t  st,
  input  logic          gen,
  input  logic [7:0]    ch,
  input  logic          last,
  output parse_state_t  st_next,
  output parse_result_t res
);

  logic                is_digit;
  logic                is_sign;
  logic [3:0]          dval;
  logic                do_take;
  logic                restart;
  logic [CntW-1:0]     len;
  phase_t              take_next;
  logic                take_ends;
  dst_t                dst;
  logic [CntW-1:0]     cnt_eff;
  logic [CntW-1:0]     cnt_inc;
  logic [AccW-1:0]     acc_base;
  logic [AccW-1:0]     acc_new;
  parse_state_t        upd;
  logic                end_ok;
  logic [AccW-1:0]     year_full;

  assign is_digit = (ch >= ChZero) && (ch <= ChNine);
  assign is_sign  = (ch == ChPlus) || (ch == ChMinus);
  assign dval     = 4'(ch - ChZero);

  // Grammar decode: pick the group to feed or the branch to take
  always_comb begin
    upd       = st;
    do_take   = 1'b0;
    restart   = 1'b0;
    len       = CntW'(2);
    take_next = st.phase;
    take_ends = 1'b0;
    dst       = DST_NONE;
    unique case (st.phase)
      PH_YEAR: begin
        do_take = 1'b1; len = gen ? CntW'(4) : CntW'(2);
        take_next = PH_MONTH; dst = DST_YEAR;
      end
      PH_MONTH: begin
        do_take = 1'b1; take_next = PH_DAY; dst = DST_MONTH;
      end
      PH_DAY: begin
        do_take = 1'b1; take_next = PH_HOUR; dst = DST_DAY;
      end
      PH_HOUR: begin
        do_take = 1'b1; take_next = gen ? PH_AFTER_HOUR : PH_MINUTE; dst = DST_HOUR;
      end
      PH_AFTER_HOUR: begin
        if (ch == ChZulu) begin
          upd.finished = 1'b1;
        end else if (is_sign) begin
          upd.phase = PH_OFFSET; upd.cnt = '0;
        end else begin
          upd.phase = PH_MINUTE; restart = 1'b1; do_take = 1'b1;
          take_next = PH_AFTER_MIN; dst = DST_MINUTE;
        end
      end
      PH_MINUTE: begin
        do_take = 1'b1; take_next = PH_AFTER_MIN; dst = DST_MINUTE;
      end
      PH_AFTER_MIN: begin
        if (ch == ChZulu) begin
          upd.finished = 1'b1;
        end else if (is_sign) begin
          upd.phase = PH_OFFSET; upd.cnt = '0;
        end else begin
          upd.phase = PH_SECOND; restart = 1'b1; do_take = 1'b1;
          take_next = PH_AFTER_SEC; dst = DST_SECOND;
        end
      end
      PH_SECOND: begin
        do_take = 1'b1; take_next = PH_AFTER_SEC; dst = DST_SECOND;
      end
      PH_AFTER_SEC: begin
        if (gen && (ch == ChDot)) begin
          upd.phase = PH_FRAC; upd.cnt = '0;
        end else if (is_sign) begin
          upd.phase = PH_OFFSET; upd.cnt = '0;
        end else begin
          upd.finished = 1'b1;
        end
      end
      PH_FRAC: begin
        do_take = 1'b1; len = CntW'(3); take_next = PH_AFTER_FRAC;
      end
      PH_AFTER_FRAC: begin
        if (is_sign) begin
          upd.phase = PH_OFFSET; upd.cnt = '0;
        end else begin
          upd.finished = 1'b1;
        end
      end
      PH_OFFSET: begin
        do_take = 1'b1; len = CntW'(4); take_ends = 1'b1;
      end
      default: begin
        upd.finished = 1'b1;
      end
    endcase

    // Digit accumulation for the selected group
    cnt_eff  = restart ? '0 : st.cnt;
    cnt_inc  = cnt_eff + CntW'(1);
    acc_base = (cnt_eff == '0) ? '0 : st.acc;
    acc_new  = AccW'(acc_base * AccW'(10)) + AccW'(dval);
    if (do_take) begin
      upd.acc = acc_base;
      if (!is_digit) begin
        upd.failed = 1'b1;
        if (restart) upd.cnt = '0;
      end else begin
        upd.acc = acc_new;
        unique case (dst)
          DST_NONE:   ;
          DST_YEAR:   upd.year   = acc_new;
          DST_MONTH:  upd.month  = acc_new[FldW-1:0];
          DST_DAY:    upd.day    = acc_new[FldW-1:0];
          DST_HOUR:   upd.hour   = acc_new[FldW-1:0];
          DST_MINUTE: upd.minute = acc_new[FldW-1:0];
          DST_SECOND: upd.second = acc_new[FldW-1:0];
          default:    ;
        endcase
        if (cnt_inc >= len) begin
          upd.cnt = '0;
          if (take_ends) upd.finished = 1'b1;
          else           upd.phase    = take_next;
        end else begin
          upd.cnt = cnt_inc;
        end
      end
    end
    // Parsing stops once failed or finished
    if (st.failed || st.finished) upd = st;
  end

  // End-of-string acceptance for partial groups
  always_comb begin
    unique case (upd.phase)
      PH_HOUR:       end_ok = gen && (upd.cnt != '0);
      PH_AFTER_HOUR: end_ok = 1'b1;
      PH_SECOND:     end_ok = (upd.cnt != '0);
      PH_AFTER_SEC:  end_ok = 1'b1;
      PH_FRAC:       end_ok = (upd.cnt != '0);
      PH_AFTER_FRAC: end_ok = 1'b1;
      PH_OFFSET:     end_ok = (upd.cnt >= CntW'(3));
      default:       end_ok = 1'b0;
    endcase
  end

  // Century mapping and result gating
  always_comb begin
    year_full = upd.year;
    if (!gen) begin
      year_full = upd.year + ((upd.year < CenturyPivot) ? Base2000 : Base1900);
    end
    res.ok = !upd.failed && (upd.finished || end_ok);
    res.year   = res.ok ? year_full  : '0;
    res.month  = res.ok ? upd.month  : '0;
    res.day    = res.ok ? upd.day    : '0;
    res.hour   = res.ok ? upd.hour   : '0;
    res.minute = res.ok ? upd.minute : '0;
    res.second = res.ok ? upd.second : '0;
  end

  // A final character returns the parser to its start state
  assign st_next = last ? StateReset : upd;

endmodule

// File: design/asn1_time_string_parser_top.sv
// Top level of the ASN.1 time string parser: input register, parser state, result register.
// A final character is held in the input register, and the parser step then loads its result into the result register.
// Throughput: one character per cycle while in_stall is low; the parser state is updated for each accepted character.
// A final character waits in the input register only while a result is held by out_stall.
// Reset (rst, synchronous) empties both registers and returns the parser to the year group.
module asn1_time_string_parser_top import asn1tp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             mode,
  input  logic [7:0]       text_byte,
  input  logic             end_of_string,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             valid_res,
  output logic [AccW-1:0]  year,
  output logic [FldW-1:0]  month,
  output logic [FldW-1:0]  day,
  output logic [FldW-1:0]  hour,
  output logic [FldW-1:0]  minute,
  output logic [FldW-1:0]  second
);

  logic          item_valid;
  logic          item_mode;
  logic [7:0]    item_byte;
  logic          item_last;
  logic          advance;
  logic          out_free;
  parse_state_t  pstate;
  parse_state_t  pstate_next;
  parse_result_t res;

  assign out_free = !out_valid || !out_stall;
  assign advance  = item_valid && (!item_last || out_free);
  assign in_stall = item_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_mode <= mode;
      item_byte <= text_byte;
      item_last <= end_of_string;
    end
  end

  asn1tp_step u_step (
    .st      (pstate),
    .gen     (item_mode),
    .ch      (item_byte),
    .last    (item_last),
    .st_next (pstate_next),
    .res     (res)
  );

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      pstate <= StateReset;
    end else if (advance) begin
      pstate <= pstate_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && item_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_last) begin
      valid_res <= res.ok;
      year      <= res.year;
      month     <= res.month;
      day       <= res.day;
      hour      <= res.hour;
      minute    <= res.minute;
      second    <= res.second;
    end
  end

endmodule
